// ===== hw/rtl/bnlf_pkg.sv =====
// Shared types and constants of the binary neighborhood rule-table filter.
`default_nettype none

package bnlf_pkg;

    localparam int MAX_FRAME_WIDTH_DEF  = 512;
    localparam int MAX_FRAME_HEIGHT_DEF = 512;

    localparam int WIN_W     = 9;
    localparam int RULE_REGS = 8;
    localparam int RULE_W    = 64;
    localparam int RULE_BITS = RULE_REGS * RULE_W;
    localparam int RI_W      = $clog2(RULE_REGS);
    localparam int RB_W      = $clog2(RULE_W);
    localparam int CFG_IDX_W = 4;

    localparam int LIT_W    = 19;
    localparam int OQ_DEPTH = 8;

    localparam logic [WIN_W-1:0] KEEP_MASK = 9'h1B6;
    localparam logic [LIT_W-1:0] LIT_MAX   = '1;

    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic cmd;
        logic pixel_in;
        logic row_end;
        logic frame_end;
    } t_in;

    typedef struct packed {
        logic             pixel_out;
        logic             out_row_end;
        logic             out_frame_end;
        logic [LIT_W-1:0] lit_total;
        logic             run_last;
    } t_out;

endpackage

`default_nettype wire

// ===== hw/rtl/binary_neighborhood_lut_filter.sv =====
// Top level of the binary 3x3 neighborhood rule-table filter.
//
// Takes one beat per clock, sustained, pixel beats and drain beats alike. The edge
// that accepts a beat also reads its line buffer entries, and the data returns in
// the next cycle (one read and one write port per buffer, with forwarding on
// back-to-back access to the same column). Its results enter an 8-entry result
// queue at the edge that ends that cycle, and o_valid comes from the queue's count
// register. o_ready drops only while the queue lacks room for two results from
// each beat in flight, which happens only when the output side stalls. Line buffer
// contents need no clearing after reset: rows not yet read as part of the
// frame come in as the background bit.
`default_nettype none

module binary_neighborhood_lut_filter #(
    parameter int MAX_FRAME_WIDTH  = bnlf_pkg::MAX_FRAME_WIDTH_DEF,
    parameter int MAX_FRAME_HEIGHT = bnlf_pkg::MAX_FRAME_HEIGHT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire bnlf_pkg::t_in                    i_data,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output bnlf_pkg::t_out                        o_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [bnlf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bnlf_pkg::RULE_W-1:0]      i_cfg_data
);

    localparam int CW  = $clog2(MAX_FRAME_WIDTH + 1);
    localparam int AW  = $clog2(MAX_FRAME_WIDTH);
    localparam int RW  = $clog2(MAX_FRAME_HEIGHT);
    localparam int QW  = $clog2(bnlf_pkg::OQ_DEPTH);
    localparam int QCW = $clog2(bnlf_pkg::OQ_DEPTH + 1);
    localparam int WW  = bnlf_pkg::WIN_W;
    localparam int LW  = bnlf_pkg::LIT_W;

    localparam logic [CW-1:0]  COL_LAST  = CW'(MAX_FRAME_WIDTH - 1);
    localparam logic [CW-1:0]  COL_LIMIT = CW'(MAX_FRAME_WIDTH);
    localparam logic [CW:0]    NX_LIMIT  = (CW + 1)'(MAX_FRAME_WIDTH);
    localparam logic [RW-1:0]  ROW_LAST  = RW'(MAX_FRAME_HEIGHT - 1);
    localparam logic [QCW-1:0] Q_DEPTH   = QCW'(bnlf_pkg::OQ_DEPTH);

    function automatic logic [WW-1:0] shift_col(logic [WW-1:0] w, logic t, logic m, logic b);
        shift_col = ((w << 1) & bnlf_pkg::KEEP_MASK) | {2'b00, t, 2'b00, m, 2'b00, b};
    endfunction

    // rule table
    logic [bnlf_pkg::RULE_BITS-1:0] r_rule;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= '0;
        end else if (i_cfg_we &&
                     i_cfg_idx < bnlf_pkg::CFG_IDX_W'(bnlf_pkg::RULE_REGS)) begin
            r_rule[{i_cfg_idx[bnlf_pkg::RI_W-1:0], bnlf_pkg::RB_W'(0)} +: bnlf_pkg::RULE_W]
                <= i_cfg_data;
        end
    end

    // accept stage: frame control
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_fw, n_fw;
    logic [CW-1:0] r_pend, n_pend;
    logic          r_bg, n_bg;

    logic          acc, is_drain, pix_ok, drn_ok, row0, ends_row, fend, rdv, bg_next;
    logic [CW:0]   c_nx;
    logic [CW-1:0] fw_new;
    logic [AW-1:0] rd_addr;

    assign acc      = i_valid && o_ready;
    assign is_drain = i_data.cmd == bnlf_pkg::CMD_DRAIN;
    assign pix_ok   = !is_drain && r_pend == '0 && r_col < COL_LIMIT;
    assign drn_ok   = is_drain && r_pend != '0;
    assign row0     = r_row == '0;
    assign c_nx     = {1'b0, r_col} + (CW + 1)'(1);
    assign ends_row = row0 ? (i_data.row_end || r_col == COL_LAST) : (c_nx >= {1'b0, r_fw});
    assign fw_new   = row0 ? c_nx[CW-1:0] : r_fw;
    assign fend     = ends_row && (i_data.frame_end || r_row == ROW_LAST);
    assign rdv      = c_nx < {1'b0, r_fw} && c_nx < NX_LIMIT;
    assign rd_addr  = is_drain ? c_nx[AW-1:0] : r_col[AW-1:0];
    assign bg_next  = r_bg ? r_rule[bnlf_pkg::RULE_BITS-1] : r_rule[0];

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_fw   = r_fw;
        n_pend = r_pend;
        n_bg   = r_bg;
        if (acc && pix_ok) begin
            if (ends_row) begin
                n_fw  = fw_new;
                n_col = '0;
                if (fend) begin
                    n_pend = fw_new;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = c_nx[CW-1:0];
            end
        end else if (acc && drn_ok) begin
            n_pend = r_pend - CW'(1);
            if (r_pend == CW'(1)) begin
                n_bg  = bg_next;
                n_col = '0;
                n_row = '0;
            end else begin
                n_col = c_nx[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_fw   <= '0;
            r_pend <= '0;
            r_bg   <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_fw   <= n_fw;
            r_pend <= n_pend;
            r_bg   <= n_bg;
        end
    end

    // beat handed to the buffer stage
    logic          r_s1_vld, r_s1_drain, r_s1_pix, r_s1_c0, r_s1_rge1, r_s1_rge2;
    logic          r_s1_emit1, r_s1_emit2, r_s1_fend, r_s1_bg, r_s1_rdv, r_s1_last;
    logic [AW-1:0] r_s1_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= acc && (pix_ok || drn_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_drain <= is_drain;
        r_s1_pix   <= i_data.pixel_in;
        r_s1_c0    <= r_col == '0;
        r_s1_rge1  <= !row0;
        r_s1_rge2  <= r_row >= RW'(2);
        r_s1_emit1 <= !row0 && r_col != '0;
        r_s1_emit2 <= ends_row && !row0;
        r_s1_fend  <= fend;
        r_s1_bg    <= r_bg;
        r_s1_rdv   <= rdv;
        r_s1_last  <= r_pend == CW'(1);
        r_s1_addr  <= r_col[AW-1:0];
    end

    // line buffers
    logic m_up  [MAX_FRAME_WIDTH];
    logic m_mid [MAX_FRAME_WIDTH];
    logic r_up_q, r_mid_q, r_fwd, r_fwd_up, r_fwd_mid;
    logic wr_en, up_eff, mid_eff;

    assign wr_en   = r_s1_vld && !r_s1_drain;
    assign up_eff  = r_fwd ? r_fwd_up : r_up_q;
    assign mid_eff = r_fwd ? r_fwd_mid : r_mid_q;

    always_ff @(posedge i_clk) begin
        r_up_q  <= m_up[rd_addr];
        r_mid_q <= m_mid[rd_addr];
        if (wr_en) begin
            m_up[r_s1_addr]  <= mid_eff;
            m_mid[r_s1_addr] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd     <= wr_en && r_s1_addr == rd_addr;
        r_fwd_up  <= mid_eff;
        r_fwd_mid <= r_s1_pix;
    end

    // window and rule lookup
    logic [WW-1:0] r_win;
    logic [LW-1:0] r_lit;
    logic          r_col0_up, r_col0_mid;

    logic [WW-1:0] bg_full, px_base, px_win, px_win2, end_win, dr_win;
    logic          px_top, px_mid, t0, m0, dr_top, dr_mid, p1, p2, pd;
    logic [1:0]    inc;
    logic [LW:0]   lit_sum;
    logic [LW-1:0] lit_sat;

    assign bg_full = {WW{r_s1_bg}};
    assign px_top  = r_s1_rge2 ? up_eff : r_s1_bg;
    assign px_mid  = r_s1_rge1 ? mid_eff : r_s1_bg;
    assign px_base = r_s1_c0 ? bg_full : r_win;
    assign px_win  = shift_col(px_base, px_top, px_mid, r_s1_pix);
    assign px_win2 = shift_col(px_win, r_s1_bg, r_s1_bg, r_s1_bg);
    assign t0      = r_s1_rge1 ? (r_s1_c0 ? mid_eff : r_col0_up) : r_s1_bg;
    assign m0      = r_s1_c0 ? r_s1_pix : r_col0_mid;
    assign end_win = shift_col(bg_full, t0, m0, r_s1_bg);
    assign dr_top  = (r_s1_rdv && r_s1_rge1) ? up_eff : r_s1_bg;
    assign dr_mid  = r_s1_rdv ? mid_eff : r_s1_bg;
    assign dr_win  = shift_col(r_win, dr_top, dr_mid, r_s1_bg);
    assign p1      = r_rule[px_win];
    assign p2      = r_rule[px_win2];
    assign pd      = r_rule[dr_win];

    assign inc     = r_s1_drain ? {1'b0, pd}
                                : {1'b0, r_s1_emit1 && p1} + {1'b0, r_s1_emit2 && p2};
    assign lit_sum = {1'b0, r_lit} + (LW + 1)'(inc);
    assign lit_sat = lit_sum[LW] ? bnlf_pkg::LIT_MAX : lit_sum[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_lit <= '0;
        end else if (r_s1_vld) begin
            if (r_s1_drain) begin
                r_win <= dr_win;
                r_lit <= r_s1_last ? '0 : lit_sat;
            end else begin
                r_win <= r_s1_fend ? end_win : px_win;
                r_lit <= lit_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && r_s1_c0) begin
            r_col0_up  <= mid_eff;
            r_col0_mid <= r_s1_pix;
        end
    end

    // result beats
    bnlf_pkg::t_out res_a, res_b;
    logic [1:0]     n_push;

    always_comb begin
        res_a  = '0;
        res_b  = '0;
        n_push = 2'd0;
        if (r_s1_vld) begin
            if (r_s1_drain) begin
                res_a.pixel_out     = pd;
                res_a.out_row_end   = r_s1_last;
                res_a.out_frame_end = r_s1_last;
                res_a.lit_total     = r_s1_last ? lit_sat : '0;
                res_a.run_last      = 1'b1;
                n_push              = 2'd1;
            end else if (r_s1_emit1 && r_s1_emit2) begin
                res_a.pixel_out   = p1;
                res_b.pixel_out   = p2;
                res_b.out_row_end = 1'b1;
                res_b.run_last    = 1'b1;
                n_push            = 2'd2;
            end else if (r_s1_emit1) begin
                res_a.pixel_out = p1;
                res_a.run_last  = 1'b1;
                n_push          = 2'd1;
            end else if (r_s1_emit2) begin
                res_a.pixel_out   = p2;
                res_a.out_row_end = 1'b1;
                res_a.run_last    = 1'b1;
                n_push            = 2'd1;
            end
        end
    end

    // result queue
    bnlf_pkg::t_out r_oq [bnlf_pkg::OQ_DEPTH];
    logic [QW-1:0]  r_wp, r_rp;
    logic [QCW-1:0] r_cnt, room;
    logic           pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_cnt != '0;
    assign o_data  = r_oq[r_rp];
    assign room    = Q_DEPTH - r_cnt;
    assign o_ready = r_s1_vld ? (room >= QCW'(4)) : (room >= QCW'(2));

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_oq[r_wp] <= res_a;
        end
        if (n_push == 2'd2) begin
            r_oq[r_wp + QW'(1)] <= res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + QW'(n_push);
            r_rp  <= r_rp + QW'(pop);
            r_cnt <= r_cnt + QCW'(n_push) - QCW'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bnlf_checker.sv =====
// Port-level checks of the binary neighborhood rule-table filter, bound to its top level.
`default_nettype none

module bnlf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire logic           i_ready,
    input wire bnlf_pkg::t_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result beat changed while stalled");

    a_frame_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_frame_end |-> o_data.out_row_end && o_data.run_last)
        else $error("frame end beat not marked as row end and run end");

    a_lit_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.out_frame_end |-> o_data.lit_total == '0)
        else $error("lit total outside a frame end beat");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

endmodule

bind binary_neighborhood_lut_filter bnlf_checker u_bnlf_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the binary 3x3 neighborhood rule-table filter.
`timescale 1ns / 100ps

module tb;

    localparam int MAXW = bnlf_pkg::MAX_FRAME_WIDTH_DEF;
    localparam int MAXH = bnlf_pkg::MAX_FRAME_HEIGHT_DEF;
    localparam int WW   = bnlf_pkg::WIN_W;
    localparam int LW   = bnlf_pkg::LIT_W;
    localparam int RW   = bnlf_pkg::RULE_W;
    localparam int RR   = bnlf_pkg::RULE_REGS;
    localparam int IW   = bnlf_pkg::CFG_IDX_W;
    localparam logic CMD_PIXEL = ~bnlf_pkg::CMD_DRAIN;
    localparam int LIMIT = 400000;

    typedef enum int {
        TBL_CLEAR, TBL_FULL, TBL_CENTER, TBL_RANDOM, TBL_INVERT_BG, TBL_HOLD_BG
    } t_table_kind;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    bnlf_pkg::t_in  i_data = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    bnlf_pkg::t_out o_data;
    logic           i_cfg_we = 1'b0;
    logic [IW-1:0]  i_cfg_idx = '0;
    logic [RW-1:0]  i_cfg_data = '0;

    binary_neighborhood_lut_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter state mirror
    logic [RW-1:0] rule_word [RR];
    logic          line_top [MAXW];
    logic          line_mid [MAXW];
    logic [WW-1:0] nbhd = '0;
    int            col_q = 0;
    int            row_q = 0;
    int            width_q = 0;
    logic          bg_q = 1'b0;
    logic [LW-1:0] lit_q = '0;
    int            pend_q = 0;

    bnlf_pkg::t_out filtered_q [$];
    int   errors = 0;
    int   beats_sent = 0;
    int   burst_left = 0;
    bit   steady = 1'b0;
    int   holds_asked = 0;
    int   holds_done = 0;
    int   hold_left = 0;
    int   ready_mode = 0;
    int   mode_left = 0;
    int   cycle_count = 0;

    initial begin
        for (int k = 0; k < RR; k++) rule_word[k] = '0;
    end

    function automatic logic rule_bit(input logic [WW-1:0] idx);
        return rule_word[idx[8:6]][idx[5:0]];
    endfunction

    function automatic logic [WW-1:0] shift_in(input logic [WW-1:0] w,
                                                input logic top, mid, bot);
        return {w[7:6], top, w[4:3], mid, w[1:0], bot};
    endfunction

    function automatic bnlf_pkg::t_out make_result(input logic pix, re, fe);
        bnlf_pkg::t_out res;
        if (pix && lit_q != bnlf_pkg::LIT_MAX) lit_q = lit_q + LW'(1);
        res.pixel_out     = pix;
        res.out_row_end   = re;
        res.out_frame_end = fe;
        res.lit_total     = fe ? lit_q : '0;
        res.run_last      = 1'b0;
        return res;
    endfunction

    function automatic logic [RW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic bnlf_pkg::t_in mk(input logic cmd, pix, re, fe);
        return bnlf_pkg::t_in'({cmd, pix, re, fe});
    endfunction

    task automatic filter_predict(input bnlf_pkg::t_in beat);
        bnlf_pkg::t_out batch [$];
        int   nx;
        logic top, mid, last, ends, t0;
        if (beat.cmd == bnlf_pkg::CMD_DRAIN) begin
            if (pend_q == 0) return;
            nx  = col_q + 1;
            top = bg_q;
            mid = bg_q;
            if (nx < width_q && nx < MAXW) begin
                top = (row_q >= 1) ? line_top[nx] : bg_q;
                mid = line_mid[nx];
            end
            nbhd = shift_in(nbhd, top, mid, bg_q);
            last = (pend_q == 1);
            batch.push_back(make_result(rule_bit(nbhd), last, last));
            pend_q--;
            col_q = nx;
            if (last) begin
                bg_q  = bg_q ? rule_bit('1) : rule_bit('0);
                col_q = 0;
                row_q = 0;
                lit_q = '0;
            end
        end else begin
            if (pend_q != 0 || col_q >= MAXW) return;
            if (row_q == 0) ends = beat.row_end || col_q == MAXW - 1;
            else            ends = col_q + 1 >= width_q;
            top = (row_q >= 2) ? line_top[col_q] : bg_q;
            mid = (row_q >= 1) ? line_mid[col_q] : bg_q;
            if (col_q == 0) nbhd = {WW{bg_q}};
            nbhd = shift_in(nbhd, top, mid, beat.pixel_in);
            line_top[col_q] = line_mid[col_q];
            line_mid[col_q] = beat.pixel_in;
            if (row_q >= 1 && col_q >= 1)
                batch.push_back(make_result(rule_bit(nbhd), 1'b0, 1'b0));
            if (ends) begin
                if (row_q >= 1)
                    batch.push_back(make_result(rule_bit(shift_in(nbhd, bg_q, bg_q, bg_q)),
                                                1'b1, 1'b0));
                if (row_q == 0) width_q = col_q + 1;
                if (beat.frame_end || row_q == MAXH - 1) begin
                    t0     = (row_q >= 1) ? line_top[0] : bg_q;
                    pend_q = width_q;
                    col_q  = 0;
                    nbhd   = shift_in({WW{bg_q}}, t0, line_mid[0], bg_q);
                end else begin
                    row_q++;
                    col_q = 0;
                end
            end else begin
                col_q++;
            end
        end
        if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
        foreach (batch[k]) filtered_q.push_back(batch[k]);
    endtask

    task automatic send_beat(input bnlf_pkg::t_in beat);
        i_valid <= 1'b1;
        i_data  <= beat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        filter_predict(beat);
        beats_sent++;
    endtask

    task automatic offer(input bnlf_pkg::t_in beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && !steady) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        send_beat(beat);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic load_table(input t_table_kind kind, input int bad_writes);
        logic [RW-1:0] words [RR];
        for (int k = 0; k < RR; k++) begin
            case (kind)
                TBL_CLEAR:  words[k] = '0;
                TBL_FULL:   words[k] = '1;
                TBL_CENTER: words[k] = 64'hFFFF_0000_FFFF_0000;
                default:    words[k] = rand64();
            endcase
        end
        if (kind == TBL_INVERT_BG) begin
            words[0][0] = 1'b1;
            words[RR-1][RW-1] = 1'b0;
        end else if (kind == TBL_HOLD_BG) begin
            words[0][0] = 1'b1;
            words[RR-1][RW-1] = 1'b1;
        end
        for (int k = 0; k < RR; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= IW'(k);
            i_cfg_data <= words[k];
            @(posedge i_clk);
            rule_word[k] = words[k];
        end
        // indexes past the table must be dropped
        for (int k = 0; k < bad_writes; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= IW'($urandom_range(RR, 2**IW - 1));
            i_cfg_data <= rand64();
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input int w, input int h, input bit row0_marked,
                              input bit fe_marked, input int density, input bit noisy);
        bnlf_pkg::t_in b;
        bit  ends;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (noisy && $urandom_range(0, 9) == 0)
                    offer(mk(bnlf_pkg::CMD_DRAIN, rbit(), rbit(), rbit()));
                ends       = (c == w - 1);
                b.cmd      = CMD_PIXEL;
                b.pixel_in = $urandom_range(0, 99) < density;
                if (r == 0)     b.row_end = row0_marked && ends;
                else if (noisy) b.row_end = rbit();
                else            b.row_end = ends;
                if (r == h - 1 && ends)  b.frame_end = fe_marked;
                else if (!ends && noisy) b.frame_end = rbit();
                else                     b.frame_end = 1'b0;
                offer(b);
            end
        end
        for (int k = 0; k < w; k++) begin
            if (noisy && $urandom_range(0, 5) == 0)
                offer(mk(CMD_PIXEL, rbit(), rbit(), rbit()));
            offer(mk(bnlf_pkg::CMD_DRAIN, rbit(), rbit(), rbit()));
        end
        if (noisy && $urandom_range(0, 1) == 0)
            offer(mk(bnlf_pkg::CMD_DRAIN, rbit(), rbit(), rbit()));
    endtask

    task automatic test_reset_table();
        send_frame(4, 3, 1'b1, 1'b1, 50, 1'b0);
    endtask

    task automatic test_special_cases();
        wait_idle();
        load_table(TBL_FULL, 3);
        offer(mk(bnlf_pkg::CMD_DRAIN, 1'b1, 1'b1, 1'b1));
        offer(mk(CMD_PIXEL, 1'b1, 1'b1, 1'b1));
        offer(mk(CMD_PIXEL, 1'b0, 1'b1, 1'b1));
        offer(mk(bnlf_pkg::CMD_DRAIN, 1'b0, 1'b0, 1'b0));
        // early frame_end, and row_end past the first row, both ignored
        offer(mk(CMD_PIXEL, 1'b1, 1'b0, 1'b1));
        offer(mk(CMD_PIXEL, 1'b0, 1'b0, 1'b0));
        offer(mk(CMD_PIXEL, 1'b1, 1'b1, 1'b0));
        offer(mk(CMD_PIXEL, 1'b0, 1'b1, 1'b0));
        offer(mk(CMD_PIXEL, 1'b1, 1'b0, 1'b1));
        offer(mk(CMD_PIXEL, 1'b1, 1'b0, 1'b1));
        repeat (3) offer(mk(bnlf_pkg::CMD_DRAIN, 1'b1, 1'b0, 1'b0));
        offer(mk(bnlf_pkg::CMD_DRAIN, 1'b0, 1'b1, 1'b1));
        wait_idle();
        load_table(TBL_CENTER, 0);
        send_frame(2, 2, 1'b1, 1'b1, 50, 1'b0);
        wait_idle();
        load_table(TBL_HOLD_BG, 0);
        send_frame(3, 3, 1'b1, 1'b1, 100, 1'b0);
        send_frame(3, 1, 1'b1, 1'b1, 0, 1'b0);
    endtask

    task automatic test_widest_row();
        wait_idle();
        load_table(TBL_RANDOM, 0);
        send_frame(MAXW, 1, 1'b0, 1'b1, 50, 1'b0);
    endtask

    task automatic test_tallest_frame();
        wait_idle();
        load_table(TBL_INVERT_BG, 0);
        send_frame(1, MAXH, 1'b1, 1'b0, 50, 1'b0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        holds_asked++;
        steady = 1'b1;
        send_frame(24, 4, 1'b1, 1'b1, 50, 1'b0);
        steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int start, phase_start, phase, w, h, dens;
        t_table_kind kind;
        start = beats_sent;
        phase = 0;
        while (beats_sent - start < 240) begin
            wait_idle();
            kind = (phase < 6) ? t_table_kind'(phase) : t_table_kind'($urandom_range(0, 5));
            load_table(kind, $urandom_range(0, 1));
            phase_start = beats_sent;
            while (beats_sent - phase_start < 40) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
                case ($urandom_range(0, 4))
                    0:       dens = 0;
                    1:       dens = 100;
                    default: dens = $urandom_range(0, 100);
                endcase
                send_frame(w, h, 1'b1, 1'b1, dens, $urandom_range(0, 3) == 0);
            end
            phase++;
        end
    endtask

    // receiver: random ready pattern, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_asked;
            hold_left  <= 300;
            i_ready    <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(32, 256);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= $urandom_range(0, 3) != 0;
                2:       i_ready <= $urandom_range(0, 3) == 0;
                default: i_ready <= ~i_ready;
            endcase
        end
    end

    task automatic check_field(input string what, input logic [LW-1:0] want, got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        bnlf_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (filtered_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got %h", $time, o_data);
                errors++;
            end else begin
                want = filtered_q.pop_front();
                check_field("pixel_out", LW'(want.pixel_out), LW'(o_data.pixel_out));
                check_field("out_row_end", LW'(want.out_row_end), LW'(o_data.out_row_end));
                check_field("out_frame_end", LW'(want.out_frame_end),
                            LW'(o_data.out_frame_end));
                check_field("lit_total", want.lit_total, o_data.lit_total);
                check_field("run_last", LW'(want.run_last), LW'(o_data.run_last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_table();
        test_special_cases();
        test_widest_row();
        test_tallest_frame();
        test_backpressure();
        test_random_frames();
        wait_idle();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
